// ----- rtl/core/sdr_pkg.sv -----
`timescale 1ns / 1ps
// shared types, register codes and constants for the stillness dimming ramp
// no dependencies; imported by every module of the block
package sdr_pkg;

    // register indexes on the configuration port (byte address / 4)
    typedef enum logic [2:0] {
        REG_DIM_ENABLE    = 3'd0,
        REG_COS_THRESHOLD = 3'd1,
        REG_STILL_TIME    = 3'd2,
        REG_DIM_RATE      = 3'd3,
        REG_BRIGHTEN_RATE = 3'd4
    } sdr_reg_idx_t;

    localparam int ADDR_W = 5;

    // Q1.24 full scale and the largest gap that still counts
    localparam logic [24:0] LEVEL_ONE  = 25'h100_0000;
    localparam logic [31:0] MAX_GAP_US = 32'd1_000_000;

    // register reset values
    localparam logic               RST_DIM_ENABLE    = 1'b0;
    localparam logic signed [15:0] RST_COS_THRESHOLD = 16'sd32767;
    localparam logic [25:0]        RST_STILL_TIME    = 26'd0;
    localparam logic [10:0]        RST_DIM_RATE      = 11'd1677;
    localparam logic [10:0]        RST_BRIGHTEN_RATE = 11'd1677;

    // configuration as seen by the datapath
    typedef struct packed {
        logic               enable;
        logic signed [15:0] cos_threshold;
        logic [25:0]        still_time_us;
        logic [10:0]        dim_rate;
        logic [10:0]        brighten_rate;
    } sdr_cfg_t;

    // one pose sample
    typedef struct packed {
        logic signed [15:0] x0;
        logic signed [15:0] x1;
        logic signed [15:0] x2;
        logic signed [15:0] z0;
        logic signed [15:0] z1;
        logic signed [15:0] z2;
        logic [31:0]        time_us;
    } sdr_pose_t;

endpackage

// ----- rtl/core/sdr_cfg_regs.sv -----
`timescale 1ns / 1ps
// apb-style configuration registers for the stillness dimming ramp
// depends on sdr_pkg
module sdr_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [sdr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output sdr_pkg::sdr_cfg_t         cfg
);
    import sdr_pkg::*;

    sdr_cfg_t     cfg_reg;
    logic         wr_en;
    sdr_reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = sdr_reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    // register writes, unmapped addresses ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= RST_DIM_ENABLE;
            cfg_reg.cos_threshold <= RST_COS_THRESHOLD;
            cfg_reg.still_time_us <= RST_STILL_TIME;
            cfg_reg.dim_rate      <= RST_DIM_RATE;
            cfg_reg.brighten_rate <= RST_BRIGHTEN_RATE;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_DIM_ENABLE:    cfg_reg.enable        <= pwdata[0];
                REG_COS_THRESHOLD: cfg_reg.cos_threshold <= pwdata[15:0];
                REG_STILL_TIME:    cfg_reg.still_time_us <= pwdata[25:0];
                REG_DIM_RATE:      cfg_reg.dim_rate      <= pwdata[10:0];
                REG_BRIGHTEN_RATE: cfg_reg.brighten_rate <= pwdata[10:0];
                default:           ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_DIM_ENABLE:    prdata = {31'd0, cfg_reg.enable};
            REG_COS_THRESHOLD: prdata = 32'(cfg_reg.cos_threshold);
            REG_STILL_TIME:    prdata = {6'd0, cfg_reg.still_time_us};
            REG_DIM_RATE:      prdata = {21'd0, cfg_reg.dim_rate};
            REG_BRIGHTEN_RATE: prdata = {21'd0, cfg_reg.brighten_rate};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/core/sdr_motion_det.sv -----
`timescale 1ns / 1ps
// reference pose store and motion test by two q4.30 dot products
// depends on sdr_pkg
module sdr_motion_det (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  sdr_pkg::sdr_cfg_t   cfg,
    input  sdr_pkg::sdr_pose_t  pose,
    output logic                motion
);
    import sdr_pkg::*;

    logic               pose_valid_reg;
    logic signed [15:0] ref_axes_reg [6];

    logic signed [31:0] px0, px1, px2, pz0, pz1, pz2;
    logic signed [33:0] dot_x, dot_z, dot_min, thr_q30;

    // exact dot products against the reference axes
    always_comb
    begin
        px0     = pose.x0 * ref_axes_reg[0];
        px1     = pose.x1 * ref_axes_reg[1];
        px2     = pose.x2 * ref_axes_reg[2];
        pz0     = pose.z0 * ref_axes_reg[3];
        pz1     = pose.z1 * ref_axes_reg[4];
        pz2     = pose.z2 * ref_axes_reg[5];
        dot_x   = 34'(px0) + 34'(px1) + 34'(px2);
        dot_z   = 34'(pz0) + 34'(pz1) + 34'(pz2);
        dot_min = (dot_x < dot_z) ? dot_x : dot_z;
        thr_q30 = {{3{cfg.cos_threshold[15]}}, cfg.cos_threshold, 15'd0};
        // first enabled sample after reset always takes the reference
        motion  = !pose_valid_reg || (dot_min < thr_q30);
    end

    // pose valid flag, only touched while enabled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pose_valid_reg <= 1'b0;
        else if (step && cfg.enable)
            pose_valid_reg <= 1'b1;
    end

    // reference pose follows the sample on motion
    always_ff @(posedge clk)
    begin
        if (step && cfg.enable && motion)
        begin
            ref_axes_reg[0] <= pose.x0;
            ref_axes_reg[1] <= pose.x1;
            ref_axes_reg[2] <= pose.x2;
            ref_axes_reg[3] <= pose.z0;
            ref_axes_reg[4] <= pose.z1;
            ref_axes_reg[5] <= pose.z2;
        end
    end

endmodule

// ----- rtl/core/sdr_level_ramp.sv -----
`timescale 1ns / 1ps
// stillness timing, elapsed gap and saturating dim level ramp
// depends on sdr_pkg
module sdr_level_ramp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  sdr_pkg::sdr_cfg_t cfg,
    input  logic [31:0]       now,
    input  logic              motion,
    output logic [24:0]       level_next,
    output logic              still
);
    import sdr_pkg::*;

    logic [31:0] last_motion_reg, last_update_reg;
    logic [24:0] level_acc_reg;

    logic [31:0] gap_raw, still_span, sum;
    logic [19:0] gap;
    logic [30:0] inc, dec;

    // gap since last update, backwards or long gaps count as zero
    always_comb
    begin
        gap_raw    = now - last_update_reg;
        gap        = (gap_raw[31] || gap_raw > MAX_GAP_US) ? 20'd0 : gap_raw[19:0];
        still_span = now - last_motion_reg;
        inc        = 31'(gap * cfg.dim_rate);
        dec        = 31'(gap * cfg.brighten_rate);
        sum        = {7'd0, level_acc_reg} + {1'b0, inc};
    end

    // still test and saturating ramp
    always_comb
    begin
        if (!cfg.enable)
        begin
            still      = 1'b0;
            level_next = 25'd0;
        end
        else
        begin
            // motion on this sample resets the still span to zero
            still = !motion && (still_span > {6'd0, cfg.still_time_us});
            if (still)
                level_next = (sum > {7'd0, LEVEL_ONE}) ? LEVEL_ONE : sum[24:0];
            else if (dec >= {6'd0, level_acc_reg})
                level_next = 25'd0;
            else
                level_next = level_acc_reg - dec[24:0];
        end
    end

    // time stamps and level accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_motion_reg <= 32'd0;
            last_update_reg <= 32'd0;
            level_acc_reg   <= 25'd0;
        end
        else if (step)
        begin
            last_update_reg <= now;
            level_acc_reg   <= level_next;
            if (!cfg.enable || motion)
                last_motion_reg <= now;
        end
    end

endmodule

// ----- rtl/core/stillness_dimming_ramp_unit.sv -----
`timescale 1ns / 1ps
// top level of the stillness dimming ramp: input register, datapath, result register
// depends on sdr_pkg, sdr_cfg_regs, sdr_motion_det, sdr_level_ramp
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------
//  pose in | in_valid / in_ready        | axis_x0..axis_x2, axis_z0..axis_z2, time_us
//  result  | out_valid / out_ready      | dim_level, is_still
//  config  | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// one pose per cycle while the result is not stalled; a transaction waits in the input register,
// is evaluated against the stored pose state and lands in the result register
// the result register is loaded, and out_valid set, as the transaction leaves the input register
// a stalled result holds the input register, which still takes one more pose
// reset clears the pose valid flag, time stamps, level and all valid bits
module stillness_dimming_ramp_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sdr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [15:0]         axis_x0,
    input  logic signed [15:0]         axis_x1,
    input  logic signed [15:0]         axis_x2,
    input  logic signed [15:0]         axis_z0,
    input  logic signed [15:0]         axis_z1,
    input  logic signed [15:0]         axis_z2,
    input  logic [31:0]                time_us,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [24:0]                dim_level,
    output logic                       is_still
);
    import sdr_pkg::*;

    sdr_cfg_t  cfg;
    sdr_pose_t pose_reg;
    logic      pose_full_reg;
    logic      out_valid_reg;
    logic [24:0] dim_level_reg;
    logic      is_still_reg;
    logic      step;
    logic      motion;
    logic      still;
    logic [24:0] level_next;

    // pipeline control
    assign step      = pose_full_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !pose_full_reg || step;
    assign out_valid = out_valid_reg;
    assign dim_level = dim_level_reg;
    assign is_still  = is_still_reg;

    sdr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sdr_motion_det u_motion (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cfg    (cfg),
        .pose   (pose_reg),
        .motion (motion)
    );

    sdr_level_ramp u_ramp (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cfg        (cfg),
        .now        (pose_reg.time_us),
        .motion     (motion),
        .level_next (level_next),
        .still      (still)
    );

    // input register valid and result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_full_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                pose_full_reg <= in_valid;
            if (step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // input and result payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pose_reg.x0      <= axis_x0;
            pose_reg.x1      <= axis_x1;
            pose_reg.x2      <= axis_x2;
            pose_reg.z0      <= axis_z0;
            pose_reg.z1      <= axis_z1;
            pose_reg.z2      <= axis_z2;
            pose_reg.time_us <= time_us;
        end
        if (step)
        begin
            dim_level_reg <= level_next;
            is_still_reg  <= still;
        end
    end

    // checks
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> dim_level <= LEVEL_ONE)
        else $error("dim level above full scale");

    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        step && !cfg.enable |=> dim_level == 25'd0 && !is_still)
        else $error("disabled transaction gave nonzero result");

    a_motion_not_still: assert property (@(posedge clk) disable iff (!rst_n)
        step && motion |=> !is_still)
        else $error("still reported on a moving sample");

    a_pose_held: assert property (@(posedge clk) disable iff (!rst_n)
        pose_full_reg && !step |=> pose_full_reg && $stable(pose_reg))
        else $error("pending pose dropped or overwritten");

endmodule
